// ===== rtl/multiword_digit_extractor_top_defines.svh =====
// Assertion macros used by the multiword digit extractor top level.
// No dependencies.
`ifndef MULTIWORD_DIGIT_EXTRACTOR_TOP_DEFINES_SVH
`define MULTIWORD_DIGIT_EXTRACTOR_TOP_DEFINES_SVH
// Property that must hold at every clock edge outside reset.
`define MDE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Property that must hold at every clock edge, reset included.
`define MDE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== rtl/mde_pkg.sv =====
// Package for the multiword digit extractor: widths, operation codes, defaults.
// No dependencies.
package mde_pkg;
   localparam int WORD_BITS_DEFAULT = 32;
   localparam int MAX_WORDS_DEFAULT = 34;
   localparam int OPND_BITS = 32;
   localparam int SHIFT_BITS = 11;
   localparam int PREC_BITS = 11;
   localparam logic [10:0] PREC_RESET = 11'd1088;

   typedef enum logic [2:0] {
      OP_CLEAR  = 3'd0,
      OP_INS_LO = 3'd1,
      OP_INS_HI = 3'd2,
      OP_DIV    = 3'd3,
      OP_MUL    = 3'd4
   } op_type;

   // Request from the sequencer to the divider.
   typedef struct packed {
      logic start;
   } div_ctl_type;
endpackage

// ===== rtl/mde_divider.sv =====
// Radix-2 restoring divider: a (32+WORD_BITS)-bit numerator by a 32-bit divisor.
// Uses mde_pkg. The remainder must be below the divisor; one quotient bit per cycle.
module mde_divider #(
   parameter int WORD_BITS = mde_pkg::WORD_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mde_pkg::div_ctl_type ctl,
   input  logic [31:0]          rem_in,
   input  logic [WORD_BITS-1:0] word_in,
   input  logic [31:0]          divisor,
   output logic                 done,
   output logic [WORD_BITS-1:0] quot,
   output logic [31:0]          rem_out
);
   localparam int CNT_BITS = $clog2(WORD_BITS + 1);

   logic [32:0]          rem_ff, rem_in_w;
   logic [WORD_BITS-1:0] q_ff, q_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic [33:0]          trial;

   always_comb begin
      rem_in_w = rem_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      trial    = '0;
      if (ctl.start) begin
         rem_in_w = {1'b0, rem_in};
         q_in     = word_in;
         cnt_in   = CNT_BITS'(WORD_BITS);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // Shift in the next numerator bit, then subtract when it fits.
         trial = {rem_ff, q_ff[WORD_BITS-1]};
         if (trial >= {2'b00, divisor}) begin
            trial = trial - {2'b00, divisor};
            q_in  = {q_ff[WORD_BITS-2:0], 1'b1};
         end else begin
            q_in  = {q_ff[WORD_BITS-2:0], 1'b0};
         end
         rem_in_w = trial[32:0];
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in_w;
      q_ff   <= q_in;
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign done    = busy_ff && (cnt_ff == CNT_BITS'(1));
   assign quot    = q_in;
   assign rem_out = rem_in_w[31:0];
endmodule

// ===== rtl/multiword_digit_extractor_top.sv =====
// Top level of the multiword digit extractor: sequencer, word memory, shared divider.
// Uses mde_pkg, mde_divider and the assertion macro header.
//
//  channel | ports     | direction | content
//  req     | req_t*    | in        | operation, operand, shift_amount
//  rsp     | rsp_t*    | out       | result, value_is_zero
//  csr     | csr_*     | in/out    | precision_bits at address 0
//
// Each item makes passes over the words in use: a clear or insert walks the words once
// (a read state, then a write state per word), then a scan pass rebuilds the zero flag. Multiply
// adds a multiply state per word for the one 32x32 multiplier; divide runs the radix-2
// divider on each word in turn. Reset clears the words in one pass
// over all MAX_WORDS words, during which no item is accepted. A stalled result holds in
// the output register; the next item is taken once the result is delivered.
`include "multiword_digit_extractor_top_defines.svh"
module multiword_digit_extractor_top #(
   parameter int WORD_BITS = mde_pkg::WORD_BITS_DEFAULT,
   parameter int MAX_WORDS = mde_pkg::MAX_WORDS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: operand [31:0], shift_amount [42:32], zero fill [47:43]
   input  logic [47:0] req_tdata,
   // tuser: operation [2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: result [31:0], value_is_zero [32], zero fill [39:33]
   output logic [39:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int IDX_BITS = $clog2(MAX_WORDS);
   localparam int CNT_BITS = $clog2(MAX_WORDS + 1);
   localparam int POS_BITS = 14;
   localparam logic [CNT_BITS-1:0] LAST_IDX = CNT_BITS'(MAX_WORDS - 1);

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_RD, S_WR, S_MUL, S_DIV_GO, S_DIV_WAIT,
      S_SCAN_RD, S_SCAN, S_DONE
   } state_type;

   state_type                 state_ff;
   logic [WORD_BITS-1:0]      mem [MAX_WORDS];
   logic [WORD_BITS-1:0]      rd_ff;
   logic [CNT_BITS-1:0]       j_ff, n_ff;
   logic [10:0]               prec_ff;
   logic [2:0]                op_ff;
   logic [31:0]               opnd_ff, acc_ff;
   logic [POS_BITS-1:0]       top_ff;
   logic                      zero_ff, nz_ff;
   logic [63:0]               prod_ff;
   logic                      rsp_valid_ff;
   logic [31:0]               rsp_res_ff;
   logic                      rsp_zero_ff;
   logic                      div_done;
   logic [WORD_BITS-1:0]      div_q;
   logic [31:0]               div_r;
   mde_pkg::div_ctl_type      div_ctl;
   logic                      cfg_wr;
   logic [CNT_BITS-1:0]       n_calc;
   logic [WORD_BITS-1:0]      ins_part;
   logic signed [POS_BITS:0]  off;
   logic [63:0]               ins_wide;

   assign cfg_wr = csr_psel && csr_penable && csr_pwrite &&
                   (csr_paddr == 2'd0);
   assign csr_pready = 1'b1;
   assign csr_prdata = {21'd0, prec_ff};

   // Words in use: the precision rounded up to whole words, at least one and at
   // most MAX_WORDS, found by comparing against each word boundary.
   always_comb begin
      n_calc = CNT_BITS'(1);
      for (int k = 1; k < MAX_WORDS; k++) begin
         if ({21'd0, prec_ff} > 32'(k * WORD_BITS)) n_calc = CNT_BITS'(k + 1);
      end
   end

   // Part of the operand that lands in word j: bits [top-32, top) from the bottom.
   always_comb begin
      off      = (POS_BITS+1)'($signed({1'b0, top_ff}) - 32 -
                 $signed({1'b0, POS_BITS'((n_ff - 1'b1 - j_ff) * WORD_BITS)}));
      ins_wide = '0;
      if (off >= 0) begin
         if (off < WORD_BITS) ins_wide = {32'd0, opnd_ff} << off[5:0];
      end else if (off > -32) begin
         ins_wide = {32'd0, opnd_ff} >> (6'(-off));
      end
      ins_part = ins_wide[WORD_BITS-1:0];
   end

   assign div_ctl.start = (state_ff == S_DIV_GO);

   mde_divider #(.WORD_BITS(WORD_BITS)) u_div (
      .clock   (clock),
      .reset   (reset),
      .ctl     (div_ctl),
      .rem_in  (acc_ff),
      .word_in (rd_ff),
      .divisor (opnd_ff),
      .done    (div_done),
      .quot    (div_q),
      .rem_out (div_r)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         j_ff         <= '0;
         prec_ff      <= mde_pkg::PREC_RESET;
         zero_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         if (cfg_wr) begin
            prec_ff  <= csr_pwdata[10:0];
            zero_ff  <= 1'b1;
            j_ff     <= '0;
            state_ff <= S_INIT;
         end else begin
            unique case (state_ff)
               S_INIT: begin
                  mem[j_ff[IDX_BITS-1:0]] <= '0;
                  j_ff <= j_ff + 1'b1;
                  if (j_ff == LAST_IDX) state_ff <= S_IDLE;
               end
               S_IDLE: begin
                  if (req_tvalid && !rsp_valid_ff) begin
                     op_ff   <= req_tuser;
                     opnd_ff <= req_tdata[31:0];
                     n_ff    <= n_calc;
                     acc_ff  <= '0;
                     if (req_tuser == mde_pkg::OP_INS_HI)
                        top_ff <= POS_BITS'(n_calc * WORD_BITS + 32) -
                                  POS_BITS'(req_tdata[42:32]);
                     else
                        top_ff <= POS_BITS'(req_tdata[42:32]);
                     if (req_tuser == mde_pkg::OP_MUL) j_ff <= n_calc - 1'b1;
                     else j_ff <= '0;
                     if (((req_tuser == mde_pkg::OP_DIV) && req_tdata[31:0] == 32'd0) ||
                         ((req_tuser == mde_pkg::OP_DIV ||
                           req_tuser == mde_pkg::OP_MUL) && zero_ff) ||
                         (req_tuser > mde_pkg::OP_MUL))
                        state_ff <= S_DONE;
                     else
                        state_ff <= S_RD;
                  end
               end
               S_RD: begin
                  rd_ff <= mem[j_ff[IDX_BITS-1:0]];
                  if (op_ff == mde_pkg::OP_MUL)      state_ff <= S_MUL;
                  else if (op_ff == mde_pkg::OP_DIV) state_ff <= S_DIV_GO;
                  else                               state_ff <= S_WR;
               end
               S_MUL: begin
                  prod_ff  <= 64'(opnd_ff) * 64'(rd_ff);
                  state_ff <= S_WR;
               end
               S_DIV_GO: state_ff <= S_DIV_WAIT;
               S_DIV_WAIT: begin
                  if (div_done) begin
                     mem[j_ff[IDX_BITS-1:0]] <= div_q;
                     acc_ff <= div_r;
                     if (j_ff == n_ff - 1'b1) begin
                        j_ff <= '0; nz_ff <= 1'b0; state_ff <= S_SCAN_RD;
                     end else begin
                        j_ff <= j_ff + 1'b1; state_ff <= S_RD;
                     end
                  end
               end
               S_WR: begin
                  if (op_ff == mde_pkg::OP_MUL) begin
                     mem[j_ff[IDX_BITS-1:0]] <= prod_ff[WORD_BITS-1:0] + acc_ff[WORD_BITS-1:0];
                     acc_ff <= 32'((prod_ff + 64'(acc_ff)) >> WORD_BITS);
                     if (j_ff == '0) begin
                        nz_ff <= 1'b0; state_ff <= S_SCAN_RD;
                     end else begin
                        j_ff <= j_ff - 1'b1; state_ff <= S_RD;
                     end
                  end else begin
                     if (op_ff == mde_pkg::OP_CLEAR) mem[j_ff[IDX_BITS-1:0]] <= '0;
                     else mem[j_ff[IDX_BITS-1:0]] <= rd_ff | ins_part;
                     if (j_ff == n_ff - 1'b1) begin
                        j_ff <= '0; nz_ff <= 1'b0; state_ff <= S_SCAN_RD;
                     end else begin
                        j_ff <= j_ff + 1'b1; state_ff <= S_RD;
                     end
                  end
               end
               S_SCAN_RD: begin
                  rd_ff    <= mem[j_ff[IDX_BITS-1:0]];
                  state_ff <= S_SCAN;
               end
               S_SCAN: begin
                  if (rd_ff != '0) nz_ff <= 1'b1;
                  if (j_ff == n_ff - 1'b1) begin
                     zero_ff  <= !(nz_ff || rd_ff != '0);
                     state_ff <= S_DONE;
                  end else begin
                     j_ff <= j_ff + 1'b1; state_ff <= S_SCAN_RD;
                  end
               end
               S_DONE: begin
                  rsp_valid_ff <= 1'b1;
                  rsp_res_ff   <= (op_ff == mde_pkg::OP_DIV || op_ff == mde_pkg::OP_MUL) ?
                                  acc_ff : 32'd0;
                  rsp_zero_ff  <= zero_ff;
                  state_ff     <= S_IDLE;
               end
               default: state_ff <= S_IDLE;
            endcase
         end
      end
   end

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff && !cfg_wr;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_zero_ff, rsp_res_ff};

   `MDE_ASSERT(a_ready_idle, clock, reset, req_tready |-> state_ff == S_IDLE, "ready outside idle")
   `MDE_ASSERT(a_one_item, clock, reset, (req_tvalid && req_tready) |=> !req_tready, "second item taken")
   `MDE_ASSERT(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> rsp_tvalid, "result dropped")
endmodule
